[design/bvss_pkg.sv]
// Package: constants and types shared by the billboard view sector select block.
package bvss_pkg;

  localparam int MASK_BITS = 20;
  localparam int BAND_BITS = 3;
  localparam int SEC_BITS  = 4;
  localparam int ACT_BITS  = 2;
  localparam int CODE_BITS = 3;

  // tan^2 of 22.5 and 67.5 deg, tan of 11.25 and 33.75 deg, unsigned Q.16
  localparam logic [18:0] TAN2_LO = 19'd11244;
  localparam logic [18:0] TAN2_HI = 19'd381972;
  localparam logic [15:0] TAN_A   = 16'd13036;
  localparam logic [15:0] TAN_B   = 16'd43790;

  typedef enum logic [BAND_BITS-1:0] {
    BAND_TOP    = 3'd0,
    BAND_UPPER  = 3'd1,
    BAND_MID    = 3'd2,
    BAND_LOWER  = 3'd3,
    BAND_BOTTOM = 3'd4
  } band_t;

  localparam logic [ACT_BITS-1:0] ACT_IDLE = 2'd0;

  // mirrored frames fold sectors above this one
  localparam logic [SEC_BITS-1:0] SEC_FOLD = 4'd8;

endpackage

[design/bvss_if.sv]
// Interfaces: sprite request channel and frame result channel.
interface bvss_in_if #(parameter int COORD_BITS = 32, parameter int FACING_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  entity_x;
  logic signed [COORD_BITS-1:0]  entity_y;
  logic signed [COORD_BITS-1:0]  entity_z;
  logic signed [FACING_BITS-1:0] facing_x;
  logic signed [FACING_BITS-1:0] facing_z;
  logic signed [COORD_BITS-1:0]  camera_x;
  logic signed [COORD_BITS-1:0]  camera_y;
  logic signed [COORD_BITS-1:0]  camera_z;
  logic [bvss_pkg::CODE_BITS-1:0] action_code;

  modport source (output valid, entity_x, entity_y, entity_z, facing_x, facing_z,
                  camera_x, camera_y, camera_z, action_code, input ready);
  modport sink   (input valid, entity_x, entity_y, entity_z, facing_x, facing_z,
                  camera_x, camera_y, camera_z, action_code, output ready);
endinterface

interface bvss_out_if;
  logic                           valid;
  logic                           ready;
  logic [bvss_pkg::BAND_BITS-1:0] elevation_band;
  logic [bvss_pkg::SEC_BITS-1:0]  view_sector;
  logic [bvss_pkg::SEC_BITS-1:0]  frame_index;
  logic                           draw_mirrored;
  logic [bvss_pkg::ACT_BITS-1:0]  action_used;

  modport source (output valid, elevation_band, view_sector, frame_index,
                  draw_mirrored, action_used, input ready);
  modport sink   (input valid, elevation_band, view_sector, frame_index,
                  draw_mirrored, action_used, output ready);
endinterface

[design/bvss_yaw.sv]
// Yaw sector pipeline: cross/dot products, quadrant fold, tangent compares.
module bvss_yaw #(
  parameter int DW = 33,
  parameter int FB = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [DW-1:0]              dx,
  input  logic signed [DW-1:0]              dz,
  input  logic signed [FB-1:0]              fx,
  input  logic signed [FB-1:0]              fz,
  output logic [bvss_pkg::SEC_BITS-1:0]     sector
);

  localparam int PW = DW + FB;
  localparam int AW = PW + 1;
  localparam int MW = AW + 16;

  logic signed [PW-1:0] p_xz_r, p_zx_r, p_xx_r, p_zz_r;
  logic signed [AW-1:0] s_r, c_r;
  logic signed [AW-1:0] s_nxt, c_nxt;
  logic [AW-1:0]        a_r, b_r;
  logic [AW-1:0]        a_nxt, b_nxt, as, bs;
  logic [1:0]           q_r, q4_nxt, q5_r;
  logic                 zero_r, zero5_r;
  logic                 sn, sz, cn, cz;
  logic [MW-1:0]        a16_r, b16_r, aa_r, ab_r, ba_r, bb_r;
  logic [2:0]           k;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xz_r <= PW'(dx * fz);
      p_zx_r <= PW'(dz * fx);
      p_xx_r <= PW'(dx * fx);
      p_zz_r <= PW'(dz * fz);
    end
  end

  assign s_nxt = AW'(p_xz_r) - AW'(p_zx_r);
  assign c_nxt = AW'(p_xx_r) + AW'(p_zz_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
      c_r <= c_nxt;
    end
  end

  always_comb begin
    sn = s_r[AW-1];
    sz = (s_r == '0);
    cn = c_r[AW-1];
    cz = (c_r == '0);
    if (!sn && !cn && !cz)             q4_nxt = 2'd0;
    else if (!sn && !sz && (cn || cz)) q4_nxt = 2'd1;
    else if ((sn || sz) && cn)         q4_nxt = 2'd2;
    else                               q4_nxt = 2'd3;
    as = sn ? AW'(-s_r) : AW'(s_r);
    bs = cn ? AW'(-c_r) : AW'(c_r);
    // odd quadrants measure from the other axis
    a_nxt = q4_nxt[0] ? bs : as;
    b_nxt = q4_nxt[0] ? as : bs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      q_r    <= q4_nxt;
      zero_r <= sz && cz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a16_r   <= {a_r, 16'b0};
      b16_r   <= {b_r, 16'b0};
      aa_r    <= MW'(a_r) * MW'(bvss_pkg::TAN_A);
      ab_r    <= MW'(a_r) * MW'(bvss_pkg::TAN_B);
      ba_r    <= MW'(b_r) * MW'(bvss_pkg::TAN_A);
      bb_r    <= MW'(b_r) * MW'(bvss_pkg::TAN_B);
      q5_r    <= q_r;
      zero5_r <= zero_r;
    end
  end

  // a boundary ray falls into the higher sector
  always_comb begin
    k = 3'(a16_r >= ba_r) + 3'(a16_r >= bb_r) + 3'(b16_r <= ab_r) + 3'(b16_r <= aa_r);
    sector = zero5_r ? '0 : bvss_pkg::SEC_BITS'({q5_r, 2'b00} + {1'b0, k});
  end

endmodule

[design/billboard_view_sector_select_core.sv]
// Top level: billboard view sector select pipeline.
// Takes one sprite request per cycle and returns its frame selection through
// registered stages: the offsets, then squares, sums and tangent products,
// then the band and sector compares and one output register. The
// pipeline advances whenever the output register is empty or being taken, so
// a stall holds every stage and a free output sustains one result per cycle.
module billboard_view_sector_select_core #(
  parameter int COORD_BITS  = 32,
  parameter int FACING_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bvss_in_if.sink                           in_ch,
  bvss_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [bvss_pkg::MASK_BITS-1:0]    cfg_wdata
);

  localparam int DW  = COORD_BITS + 1;
  localparam int SQ  = 2 * DW;
  localparam int H2W = SQ + 1;
  localparam int EW  = H2W + 19;
  localparam int NV  = 6;

  logic [bvss_pkg::MASK_BITS-1:0] mask_r;
  logic [NV-1:0]                  vld_r;
  logic                           en;

  logic signed [DW-1:0]          dx_r, dy_r, dz_r, dzs_r;
  logic signed [FACING_BITS-1:0] fx_r, fz_r;
  logic [bvss_pkg::ACT_BITS-1:0] act_r [1:5];
  logic [DW-1:0]                 mx, my, mz;
  logic [SQ-1:0]                 xx_r, zz_r, yy_r;
  logic [H2W-1:0]                h2_r;
  logic [EW-1:0]                 l3_r, l4_r, lo_r, hi_r;
  logic [1:0]                    dys_r [2:4];   // {negative, zero}
  bvss_pkg::band_t               band_nxt, band5_r, band_r;
  logic [bvss_pkg::SEC_BITS-1:0] sec_nxt, sec_r, frame_r;
  logic                          flip_r;
  logic [bvss_pkg::ACT_BITS-1:0] act_o_r;
  logic                          mir;

  assign en          = !vld_r[NV-1] || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_ch.valid};
    end
  end

  // stage 1: offsets, zero-vector substitution for the yaw path
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= DW'(in_ch.camera_x) - DW'(in_ch.entity_x);
      dy_r  <= DW'(in_ch.camera_y) - DW'(in_ch.entity_y);
      dz_r  <= DW'(in_ch.camera_z) - DW'(in_ch.entity_z);
      if (in_ch.camera_x == in_ch.entity_x && in_ch.camera_z == in_ch.entity_z) begin
        dzs_r <= DW'(1);
      end else begin
        dzs_r <= DW'(in_ch.camera_z) - DW'(in_ch.entity_z);
      end
      fx_r <= in_ch.facing_x;
      if (in_ch.facing_x == '0 && in_ch.facing_z == '0) begin
        fz_r <= FACING_BITS'(1);
      end else begin
        fz_r <= in_ch.facing_z;
      end
      act_r[1] <= (in_ch.action_code[2]) ? bvss_pkg::ACT_IDLE
                                          : in_ch.action_code[1:0];
      act_r[2] <= act_r[1];
      act_r[3] <= act_r[2];
      act_r[4] <= act_r[3];
      act_r[5] <= act_r[4];
    end
  end

  bvss_yaw #(.DW(DW), .FB(FACING_BITS)) u_yaw (
    .clk    (clk),
    .en     (en),
    .dx     (dx_r),
    .dz     (dzs_r),
    .fx     (fx_r),
    .fz     (fz_r),
    .sector (sec_nxt)
  );

  // elevation: squares, then sums and tan^2 products, then compares
  assign mx = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign my = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
  assign mz = dz_r[DW-1] ? DW'(-dz_r) : DW'(dz_r);

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r     <= SQ'(mx) * SQ'(mx);
      yy_r     <= SQ'(my) * SQ'(my);
      zz_r     <= SQ'(mz) * SQ'(mz);
      dys_r[2] <= {dy_r[DW-1], dy_r == '0};
      h2_r     <= H2W'(xx_r) + H2W'(zz_r);
      l3_r     <= EW'({yy_r, 16'b0});
      dys_r[3] <= dys_r[2];
      lo_r     <= EW'(h2_r) * EW'(bvss_pkg::TAN2_LO);
      hi_r     <= EW'(h2_r) * EW'(bvss_pkg::TAN2_HI);
      l4_r     <= l3_r;
      dys_r[4] <= dys_r[3];
      band5_r  <= band_nxt;
    end
  end

  always_comb begin
    if (dys_r[4][0]) begin
      band_nxt = bvss_pkg::BAND_MID;
    end else if (!dys_r[4][1]) begin
      if (l4_r > hi_r)      band_nxt = bvss_pkg::BAND_TOP;
      else if (l4_r > lo_r) band_nxt = bvss_pkg::BAND_UPPER;
      else                  band_nxt = bvss_pkg::BAND_MID;
    end else begin
      if (l4_r <= lo_r)      band_nxt = bvss_pkg::BAND_MID;
      else if (l4_r <= hi_r) band_nxt = bvss_pkg::BAND_LOWER;
      else                   band_nxt = bvss_pkg::BAND_BOTTOM;
    end
  end

  assign mir = mask_r[{band5_r[2:0], act_r[5]}];

  // stage 6: output register with mirroring fold
  always_ff @(posedge clk) begin
    if (en) begin
      band_r  <= band5_r;
      sec_r   <= sec_nxt;
      act_o_r <= act_r[5];
      if (mir && sec_nxt > bvss_pkg::SEC_FOLD) begin
        frame_r <= bvss_pkg::SEC_BITS'(5'd16 - {1'b0, sec_nxt});
        flip_r  <= 1'b1;
      end else begin
        frame_r <= sec_nxt;
        flip_r  <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = vld_r[NV-1];
  assign out_ch.elevation_band = band_r;
  assign out_ch.view_sector    = sec_r;
  assign out_ch.frame_index    = frame_r;
  assign out_ch.draw_mirrored  = flip_r;
  assign out_ch.action_used    = act_o_r;

  a_flip_fold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && flip_r |-> sec_r > bvss_pkg::SEC_FOLD && frame_r == 4'(5'd16 - {1'b0, sec_r}))
    else $error("flipped frame does not mirror its sector");

  a_noflip_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !flip_r |-> frame_r == sec_r)
    else $error("unflipped frame differs from sector");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(sec_r) && $stable(band_r))
    else $error("stalled result changed");

endmodule

[tb/bvss_tb_if.sv]
// Testbench package: request and result record types.
package bvss_tb_pkg;

  typedef struct packed {
    logic signed [31:0] ex, ey, ez;
    logic signed [15:0] fx, fz;
    logic signed [31:0] cx, cy, cz;
    logic [2:0]         act;
  } sprite_req_t;

  typedef struct packed {
    logic [bvss_pkg::BAND_BITS-1:0] band;
    logic [bvss_pkg::SEC_BITS-1:0]  sec;
    logic [bvss_pkg::SEC_BITS-1:0]  frame;
    logic                           flip;
    logic [bvss_pkg::ACT_BITS-1:0]  act;
  } frame_sel_t;
endpackage

[tb/billboard_view_sector_select_core_tb.sv]
// Testbench: random and directed sprite requests checked against a frame predictor.
module billboard_view_sector_select_core_tb;

  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 780;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bvss_pkg::MASK_BITS-1:0] cfg_wdata = '0;

  bvss_in_if #(.COORD_BITS(32), .FACING_BITS(16)) in_ch();
  bvss_out_if out_ch();

  billboard_view_sector_select_core #(.COORD_BITS(32), .FACING_BITS(16)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [bvss_pkg::MASK_BITS-1:0] mirror_bits = '0;
  bvss_tb_pkg::frame_sel_t pending_frames[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;

  // wide signed arithmetic, 130 bits is ample for 33-bit offsets
  typedef logic signed [129:0] wide_t;

  function automatic bvss_pkg::band_t predict_band(wide_t dx, wide_t dy, wide_t dz);
    wide_t h2, l, lo, hi;
    h2 = dx * dx + dz * dz;
    l  = (dy * dy) <<< 16;
    lo = h2 * wide_t'(bvss_pkg::TAN2_LO);
    hi = h2 * wide_t'(bvss_pkg::TAN2_HI);
    if (dy == 0) return bvss_pkg::BAND_MID;
    if (dy > 0) begin
      if (l > hi) return bvss_pkg::BAND_TOP;
      if (l > lo) return bvss_pkg::BAND_UPPER;
      return bvss_pkg::BAND_MID;
    end
    if (l <= lo) return bvss_pkg::BAND_MID;
    if (l <= hi) return bvss_pkg::BAND_LOWER;
    return bvss_pkg::BAND_BOTTOM;
  endfunction

  function automatic logic [3:0] predict_sector(wide_t dx, wide_t dz, wide_t fx, wide_t fz);
    wide_t s, c, a, b, t;
    logic [1:0] q;
    logic [3:0] k;
    if (dx == 0 && dz == 0) dz = wide_t'(1);
    if (fx == 0 && fz == 0) fz = wide_t'(1);
    s = dx * fz - dz * fx;
    c = dx * fx + dz * fz;
    if (s == 0 && c == 0) return 4'd0;
    if (s >= 0 && c > 0) q = 2'd0;
    else if (s > 0 && c <= 0) q = 2'd1;
    else if (s <= 0 && c < 0) q = 2'd2;
    else q = 2'd3;
    a = (s < 0) ? -s : s;
    b = (c < 0) ? -c : c;
    if (q[0]) begin
      t = a; a = b; b = t;
    end
    k = '0;
    if ((a <<< 16) >= b * wide_t'(bvss_pkg::TAN_A)) k++;
    if ((a <<< 16) >= b * wide_t'(bvss_pkg::TAN_B)) k++;
    if ((b <<< 16) <= a * wide_t'(bvss_pkg::TAN_B)) k++;
    if ((b <<< 16) <= a * wide_t'(bvss_pkg::TAN_A)) k++;
    return {q, 2'b00} + k;
  endfunction

  function automatic bvss_tb_pkg::frame_sel_t predict_frame(bvss_tb_pkg::sprite_req_t r);
    bvss_tb_pkg::frame_sel_t f;
    wide_t dx, dy, dz;
    dx = wide_t'(r.cx) - wide_t'(r.ex);
    dy = wide_t'(r.cy) - wide_t'(r.ey);
    dz = wide_t'(r.cz) - wide_t'(r.ez);
    f.act  = (r.act >= 3'd4) ? bvss_pkg::ACT_IDLE : r.act[1:0];
    f.band = predict_band(dx, dy, dz);
    f.sec  = predict_sector(dx, dz, wide_t'(r.fx), wide_t'(r.fz));
    f.frame = f.sec;
    f.flip  = 1'b0;
    if (mirror_bits[{f.band, f.act}] && f.sec > bvss_pkg::SEC_FOLD) begin
      f.frame = 4'd0 - f.sec;
      f.flip  = 1'b1;
    end
    return f;
  endfunction

  // requests queued by the driver process; expectations pushed on acceptance
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      bvss_tb_pkg::sprite_req_t r;
      r = '{in_ch.entity_x, in_ch.entity_y, in_ch.entity_z, in_ch.facing_x,
            in_ch.facing_z, in_ch.camera_x, in_ch.camera_y, in_ch.camera_z,
            in_ch.action_code};
      pending_frames.push_back(predict_frame(r));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bvss_tb_pkg::frame_sel_t got, want;
      got = '{out_ch.elevation_band, out_ch.view_sector, out_ch.frame_index,
              out_ch.draw_mirrored, out_ch.action_used};
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_frames.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("frame mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off on request
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (long_hold) out_ch.ready <= 1'b0;
    else if (!rst_n) out_ch.ready <= 1'b0;
    else case ($urandom_range(0, 3))
      0: out_ch.ready <= 1'b0;
      default: out_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !long_hold) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 255)) - 128;
      default: return $urandom();
    endcase
  endfunction

  function automatic bvss_tb_pkg::sprite_req_t rand_req();
    bvss_tb_pkg::sprite_req_t r;
    r.ex = rand_coord(); r.ey = rand_coord(); r.ez = rand_coord();
    r.fx = 16'($urandom()); r.fz = 16'($urandom());
    if ($urandom_range(0, 9) == 0) begin
      r.fx = '0; r.fz = '0;
    end
    r.cx = rand_coord(); r.cy = rand_coord(); r.cz = rand_coord();
    // near neighbours reach every band and exact boundaries more often
    if ($urandom_range(0, 2) == 0) begin
      r.cx = r.ex + ($signed($urandom_range(0, 64)) - 32);
      r.cy = r.ey + ($signed($urandom_range(0, 64)) - 32);
      r.cz = r.ez + ($signed($urandom_range(0, 64)) - 32);
    end
    r.act = 3'($urandom_range(0, 7));
    return r;
  endfunction

  task automatic send_req(bvss_tb_pkg::sprite_req_t r);
    in_ch.valid <= 1'b1;
    {in_ch.entity_x, in_ch.entity_y, in_ch.entity_z, in_ch.facing_x, in_ch.facing_z,
     in_ch.camera_x, in_ch.camera_y, in_ch.camera_z, in_ch.action_code} <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_and_write(logic [bvss_pkg::MASK_BITS-1:0] m);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    mirror_bits <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  localparam int N_DIRECTED = 14;
  bvss_tb_pkg::sprite_req_t directed_reqs[N_DIRECTED];
  bvss_tb_pkg::frame_sel_t directed_want[N_DIRECTED];
  bit directed_known[N_DIRECTED];

  initial begin
    int burst;
    in_ch.valid = 1'b0;
    {in_ch.entity_x, in_ch.entity_y, in_ch.entity_z, in_ch.facing_x, in_ch.facing_z,
     in_ch.camera_x, in_ch.camera_y, in_ch.camera_z, in_ch.action_code} = '0;
    // zero offset, zero facing: mid band, sector 0
    directed_reqs[0] = '{0, 0, 0, 0, 0, 0, 0, 0, 3'd0};
    directed_want[0] = '{bvss_pkg::BAND_MID, 4'd0, 4'd0, 1'b0, bvss_pkg::ACT_IDLE};
    directed_known[0] = 1;
    directed_reqs[1] = '{0, 0, 0, 0, 0, 0, 100, 0, 3'd7};
    directed_want[1] = '{bvss_pkg::BAND_TOP, 4'd0, 4'd0, 1'b0, bvss_pkg::ACT_IDLE};
    directed_known[1] = 1;
    // facing +x, camera straight below: direction +z sits a quarter turn back
    directed_reqs[2] = '{0, 0, 0, 16'sd16384, 0, 0, -100, 0, 3'd3};
    directed_want[2] = '{bvss_pkg::BAND_BOTTOM, 4'd12, 4'd12, 1'b0, 2'd3};
    directed_known[2] = 1;
    directed_reqs[3] = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 16'sh7fff,
                         32'sh80000000, 32'sh80000000, 32'sh80000000, 3'd1};
    directed_reqs[4] = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh8000,
                         32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 3'd2};
    // camera behind, left, right, and on wedge boundaries
    directed_reqs[5] = '{0, 0, 0, 0, 16'sd16384, 0, 0, -5, 3'd4};
    directed_reqs[6] = '{0, 0, 0, 0, 16'sd16384, -5, 0, 0, 3'd5};
    directed_reqs[7] = '{0, 0, 0, 0, 16'sd16384, 5, 0, 0, 3'd6};
    directed_reqs[8] = '{0, 0, 0, 0, 16'sd16384, 5, 0, 5, 3'd1};
    directed_reqs[9] = '{0, 0, 0, 0, 16'sd16384, -5, 0, 5, 3'd2};
    directed_reqs[10] = '{0, 0, 0, 0, 16'sd16384, -13036, 0, 65536, 3'd0};
    // height against band thresholds: dy^2*2^16 against H2*tan^2
    directed_reqs[11] = '{0, 0, 0, 0, 0, 65536, 11244, 0, 3'd1};
    directed_reqs[12] = '{0, 0, 0, 0, 0, 65536, -11244, 0, 3'd2};
    directed_reqs[13] = '{0, 0, 0, 16'sh8000, 16'sh7fff, -3, 7, -9, 3'd3};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_reqs[i]) begin
      bvss_tb_pkg::frame_sel_t p;
      p = predict_frame(directed_reqs[i]);
      if (directed_known[i] && p !== directed_want[i]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: expected %p predicted %p", i, directed_want[i], p);
      end
      send_req(directed_reqs[i]);
    end

    drain_and_write(20'hfffff);
    foreach (directed_reqs[i]) send_req(directed_reqs[i]);

    // random part over several mask settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: drain_and_write(20'($urandom()));
        1: drain_and_write(20'h00000);
        2: drain_and_write(20'haaaaa);
        default: drain_and_write(20'h55555);
      endcase
      if (phase == 1) begin
        // long receiver hold-off while requests keep coming
        fork
          begin
            long_hold = 1'b1;
            repeat (200) @(posedge clk);
            long_hold = 1'b0;
          end
          for (int i = 0; i < 40; i++) send_req(rand_req());
        join
      end
      for (int n = 0; n < N_RANDOM / 4;) begin
        burst = $urandom_range(1, 20);
        for (int i = 0; i < burst && n < N_RANDOM / 4; i++) begin
          send_req(rand_req());
          n++;
        end
        in_ch.valid <= 1'b0;
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
